// ===== src/bfm_pkg.sv =====
// ----------------------------------------------------------------------------
// bfm_pkg
// shared types and constants of the bloom filter check/add block
// ----------------------------------------------------------------------------
package bfm_pkg;

	typedef logic [1:0] opcode_t;

	localparam opcode_t OP_CHECK = 2'd0;
	localparam opcode_t OP_ADD   = 2'd1;
	localparam opcode_t OP_CLEAR = 2'd2;
	localparam opcode_t OP_NOP   = 2'd3;

	localparam int KEY_LEN_W = 11;
	localparam int MOD_W     = 25;
	localparam int NH_W      = 6;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_BITS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES = 1'd1;

	localparam logic [MOD_W-1:0] NUM_BITS_RST   = 25'd16777216;
	localparam logic [NH_W-1:0]  NUM_HASHES_RST = 6'd7;
	localparam logic [NH_W-1:0]  MAX_HASHES     = 6'd32;

	localparam logic [31:0] SEED_FIRST = 32'h9747b28c;
	localparam logic [31:0] MIX_MUL    = 32'h5bd1e995;
	localparam logic [32:0] TWO_POW_32 = 33'h1_0000_0000;

	typedef struct packed {
		opcode_t              op;
		logic [KEY_LEN_W-1:0] len;
		logic [31:0]          tail;
		logic                 ovf;
		logic                 bank;
	} job_t;

	typedef struct packed {
		logic key_done;
		logic init_busy;
	} back_status_t;

	function automatic logic [31:0] mul_mix(input logic [31:0] x);
		mul_mix = x * MIX_MUL;
	endfunction

endpackage

// ===== src/bfm_if.sv =====
// ----------------------------------------------------------------------------
// bfm_if
// request and response channels of the bloom filter block
// ----------------------------------------------------------------------------
interface bfm_req_if;
	logic             valid;
	logic             ready;
	bfm_pkg::opcode_t opcode;
	logic [31:0]      key_word;
	logic [2:0]       byte_count;
	logic             last_word;

	modport source(output valid, opcode, key_word, byte_count, last_word, input ready);
	modport sink(input valid, opcode, key_word, byte_count, last_word, output ready);
endinterface

interface bfm_resp_if;
	logic valid;
	logic ready;
	logic present;
	logic status;

	modport source(output valid, present, status, input ready);
	modport sink(input valid, present, status, output ready);
endinterface

// ===== src/bloom_filter_murmur2_check_add.sv =====
// ----------------------------------------------------------------------------
// bloom_filter_murmur2_check_add
// bloom filter with murmur2 double hashing: check, add and clear
// ----------------------------------------------------------------------------
// req carries key words (little-endian bytes, byte_count valid, last_word on
// the final word) with an opcode; only the opcode of the last word picks check
// or add. opcode clear zeroes the bit store and returns nothing. resp carries
// one present/status pair per finished key.
// cfg_we/cfg_index/cfg_wdata write num_bits (index 0) and num_hashes (index 1)
// while the block is idle.
// words are packed into a two-bank key ram at one per cycle while req.ready is
// high; a short job queue lets the next key gather while the back end works on
// the current one. per key the back end runs the two hash passes over the full
// words, three serial remainders, then one bit store ram probe per hash, a
// check stopping at its first miss; clear sweeps the store one row per cycle.
// after reset the same clearing pass runs first and req.ready stays low until
// it ends. a stalled resp holds one result in its output register; the back
// end then waits, and req stalls once two keys are outstanding or the queue
// is full.
// ----------------------------------------------------------------------------
module bloom_filter_murmur2_check_add #(
	parameter longint unsigned BIT_CAPACITY  = 64'd16777216,
	parameter int              MAX_KEY_BYTES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bfm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfm_pkg::MOD_W-1:0]     cfg_wdata,
	bfm_req_if.sink                       req,
	bfm_resp_if.source                    resp
);

	localparam int KEY_WORDS = (MAX_KEY_BYTES + 3) / 4;
	localparam int KIW       = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
	localparam int ROWS      = int'((BIT_CAPACITY + 64'd31) / 64'd32);
	localparam int AW        = $clog2(ROWS);
	localparam int MW        = bfm_pkg::MOD_W;
	localparam int NW        = bfm_pkg::NH_W;

	logic [MW-1:0] num_bits_q;
	logic [NW-1:0] num_hashes_q;
	logic [MW-1:0] nb_one;
	logic [MW-1:0] m_eff;
	logic [NW-1:0] hn_eff;

	bfm_pkg::back_status_t status;
	bfm_pkg::job_t         push_data;
	bfm_pkg::job_t         head;
	logic                  push;
	logic                  pop;
	logic                  fifo_full;
	logic                  fifo_empty;
	logic                  kw_en;
	logic [KIW:0]          kw_addr;
	logic [31:0]           kw_data;
	logic [KIW:0]          kr_addr;
	logic [31:0]           kr_data;
	logic [AW-1:0]         br_addr;
	logic [31:0]           br_data;
	logic                  bw_en;
	logic [AW-1:0]         bw_addr;
	logic [31:0]           bw_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_bits_q   <= bfm_pkg::NUM_BITS_RST;
			num_hashes_q <= bfm_pkg::NUM_HASHES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bfm_pkg::CFG_NUM_BITS:   num_bits_q   <= cfg_wdata;
				bfm_pkg::CFG_NUM_HASHES: num_hashes_q <= cfg_wdata[NW-1:0];
				default:                 num_bits_q   <= num_bits_q;
			endcase
		end
	end

	assign nb_one = (num_bits_q == '0) ? MW'(1) : num_bits_q;
	assign m_eff  = ({39'b0, nb_one} > BIT_CAPACITY) ? MW'(BIT_CAPACITY) : nb_one;
	assign hn_eff = (num_hashes_q > bfm_pkg::MAX_HASHES) ? bfm_pkg::MAX_HASHES
		: num_hashes_q;

	bfm_front #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES),
		.KIW           (KIW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.status    (status),
		.fifo_full (fifo_full),
		.push      (push),
		.push_data (push_data),
		.kw_en     (kw_en),
		.kw_addr   (kw_addr),
		.kw_data   (kw_data)
	);

	bfm_fifo #(
		.T (bfm_pkg::job_t)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.full      (fifo_full),
		.empty     (fifo_empty)
	);

	bfm_ram #(
		.WIDTH (32),
		.DEPTH (2 << KIW)
	) u_key_ram (
		.clk   (clk),
		.we    (kw_en),
		.waddr (kw_addr),
		.wdata (kw_data),
		.raddr (kr_addr),
		.rdata (kr_data)
	);

	bfm_ram #(
		.WIDTH (32),
		.DEPTH (ROWS)
	) u_bit_ram (
		.clk   (clk),
		.we    (bw_en),
		.waddr (bw_addr),
		.wdata (bw_data),
		.raddr (br_addr),
		.rdata (br_data)
	);

	bfm_back #(
		.KIW  (KIW),
		.ROWS (ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.modulus    (m_eff),
		.hashes     (hn_eff),
		.head       (head),
		.fifo_empty (fifo_empty),
		.pop        (pop),
		.kr_addr    (kr_addr),
		.kr_data    (kr_data),
		.br_addr    (br_addr),
		.br_data    (br_data),
		.bw_en      (bw_en),
		.bw_addr    (bw_addr),
		.bw_data    (bw_data),
		.status     (status),
		.resp       (resp)
	);

endmodule

// ===== src/bfm_ram.sv =====
// ----------------------------------------------------------------------------
// bfm_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module bfm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/bfm_fifo.sv =====
// ----------------------------------------------------------------------------
// bfm_fifo
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module bfm_fifo #(
	parameter type T = logic
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     push_data,
	input  logic pop,
	output T     head,
	output logic full,
	output logic empty
);

	logic [1:0] cnt_q;
	T           e0_q;
	T           e1_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = e0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					e0_q <= push_data;
				end else begin
					e1_q <= push_data;
				end
			end
			2'b01: e0_q <= e1_q;
			2'b11: begin
				if (cnt_q == 2'd1) begin
					e0_q <= push_data;
				end else begin
					e0_q <= e1_q;
					e1_q <= push_data;
				end
			end
			default: e0_q <= e0_q;
		endcase
	end

endmodule

// ===== src/bfm_front.sv =====
// ----------------------------------------------------------------------------
// bfm_front
// takes requests, packs key bytes into the key ram and queues jobs
// ----------------------------------------------------------------------------
module bfm_front #(
	parameter int MAX_KEY_BYTES = 64,
	parameter int KIW           = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bfm_req_if.sink               req,
	input  bfm_pkg::back_status_t status,
	input  logic                  fifo_full,
	output logic                  push,
	output bfm_pkg::job_t         push_data,
	output logic                  kw_en,
	output logic [KIW:0]          kw_addr,
	output logic [31:0]           kw_data
);

	localparam int LW = bfm_pkg::KEY_LEN_W;

	logic [LW-1:0]  len_q;
	logic [31:0]    hold_q;
	logic [1:0]     hcnt_q;
	logic [KIW-1:0] widx_q;
	logic           ovf_q;
	logic           bank_q;
	logic [1:0]     outst_q;

	logic [2:0]  cnt;
	logic [31:0] wmask;
	logic [63:0] comb64;
	logic [2:0]  total;
	logic [LW:0] len_sum;
	logic        over;
	logic        accept;
	logic        data_op;
	logic        gather;
	logic        ovf_n;
	logic [31:0] hold_n;
	logic        key_push;

	assign req.ready = !status.init_busy && !fifo_full && (outst_q != 2'd2);
	assign accept    = req.valid && req.ready;
	assign data_op   = accept && (req.opcode == bfm_pkg::OP_CHECK ||
		req.opcode == bfm_pkg::OP_ADD);

	always_comb begin
		cnt = (req.byte_count > 3'd4) ? 3'd4 : req.byte_count;
		for (int j = 0; j < 4; j++) begin
			wmask[8*j +: 8] = (3'(j) < cnt) ? req.key_word[8*j +: 8] : 8'h00;
		end
		comb64  = {32'b0, hold_q} | ({32'b0, wmask} << {hcnt_q, 3'b000});
		total   = {1'b0, hcnt_q} + cnt;
		len_sum = {1'b0, len_q} + {{(LW-2){1'b0}}, cnt};
		over    = len_sum > (LW+1)'(MAX_KEY_BYTES);
		gather  = data_op && !ovf_q && !over;
		ovf_n   = ovf_q || (data_op && over);
		hold_n  = total[2] ? comb64[63:32] : comb64[31:0];
	end

	assign key_push = data_op && req.last_word;
	assign push     = key_push || (accept && req.opcode == bfm_pkg::OP_CLEAR);

	always_comb begin
		push_data.op   = req.opcode;
		push_data.len  = gather ? len_sum[LW-1:0] : len_q;
		push_data.tail = gather ? hold_n : hold_q;
		push_data.ovf  = ovf_n;
		push_data.bank = bank_q;
	end

	assign kw_en   = gather && total[2];
	assign kw_addr = {bank_q, widx_q};
	assign kw_data = comb64[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			hold_q  <= '0;
			hcnt_q  <= '0;
			widx_q  <= '0;
			ovf_q   <= 1'b0;
			bank_q  <= 1'b0;
			outst_q <= '0;
		end else begin
			case ({key_push, status.key_done})
				2'b10:   outst_q <= outst_q + 2'd1;
				2'b01:   outst_q <= outst_q - 2'd1;
				default: outst_q <= outst_q;
			endcase
			if (data_op) begin
				if (req.last_word) begin
					len_q  <= '0;
					hold_q <= '0;
					hcnt_q <= '0;
					widx_q <= '0;
					ovf_q  <= 1'b0;
					bank_q <= !bank_q;
				end else begin
					ovf_q <= ovf_n;
					if (gather) begin
						len_q  <= len_sum[LW-1:0];
						hold_q <= hold_n;
						hcnt_q <= total[1:0];
						if (total[2]) begin
							widx_q <= widx_q + 1'b1;
						end
					end
				end
			end
		end
	end

endmodule

// ===== src/bfm_mod.sv =====
// ----------------------------------------------------------------------------
// bfm_mod
// bit-serial remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module bfm_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [32:0]               dividend,
	input  logic [bfm_pkg::MOD_W-1:0] modulus,
	output logic                      done,
	output logic [bfm_pkg::MOD_W-1:0] rem
);

	localparam int MW = bfm_pkg::MOD_W;

	logic [32:0]   dq_q;
	logic [MW-1:0] rem_q;
	logic [5:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [MW:0]   tr;
	logic [MW:0]   diff;

	assign tr   = {rem_q, dq_q[32]};
	assign diff = tr - {1'b0, modulus};
	assign done = done_q;
	assign rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= 6'd33;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[31:0], 1'b0};
			rem_q <= (tr >= {1'b0, modulus}) ? diff[MW-1:0] : tr[MW-1:0];
		end
	end

endmodule

// ===== src/bfm_back.sv =====
// ----------------------------------------------------------------------------
// bfm_back
// hash sequencer, probe loop and bit store sweeps
// ----------------------------------------------------------------------------
module bfm_back #(
	parameter int KIW  = 4,
	parameter int ROWS = 524288
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [bfm_pkg::MOD_W-1:0]  modulus,
	input  logic [bfm_pkg::NH_W-1:0]   hashes,
	input  bfm_pkg::job_t              head,
	input  logic                       fifo_empty,
	output logic                       pop,
	output logic [KIW:0]               kr_addr,
	input  logic [31:0]                kr_data,
	output logic [$clog2(ROWS)-1:0]    br_addr,
	input  logic [31:0]                br_data,
	output logic                       bw_en,
	output logic [$clog2(ROWS)-1:0]    bw_addr,
	output logic [31:0]                bw_data,
	output bfm_pkg::back_status_t      status,
	bfm_resp_if.source                 resp
);

	localparam int AW = $clog2(ROWS);
	localparam int MW = bfm_pkg::MOD_W;
	localparam int LW = bfm_pkg::KEY_LEN_W;

	typedef enum logic [15:0] {
		S_CLR   = 16'h0001,
		S_IDLE  = 16'h0002,
		S_WRD   = 16'h0004,
		S_K1    = 16'h0008,
		S_K2    = 16'h0010,
		S_KX    = 16'h0020,
		S_TAIL  = 16'h0040,
		S_FIN1  = 16'h0080,
		S_FIN2  = 16'h0100,
		S_MST   = 16'h0200,
		S_MWT   = 16'h0400,
		S_PINIT = 16'h0800,
		S_PRD   = 16'h1000,
		S_PCHK  = 16'h2000,
		S_PFIX  = 16'h4000,
		S_RES   = 16'h8000
	} state_t;

	state_t                        state_q;
	bfm_pkg::job_t                 job_q;
	logic                          init_q;
	logic [AW-1:0]                 clr_q;
	logic                          pass_q;
	logic [LW-3:0]                 widx_q;
	logic [31:0]                   h_q;
	logic [31:0]                   hm_q;
	logic [31:0]                   k_q;
	logic [31:0]                   a_q;
	logic [31:0]                   b_q;
	logic [31:0]                   x_q;
	logic [MW-1:0]                 r_q;
	logic [MW-1:0]                 bm_q;
	logic [MW-1:0]                 c_q;
	logic [MW+1:0]                 t_q;
	logic [1:0]                    msel_q;
	logic [bfm_pkg::NH_W-1:0]      i_q;
	logic                          allhit_q;
	logic                          res_present_q;
	logic                          res_status_q;
	logic                          oval_q;
	logic                          opres_q;
	logic                          ostat_q;

	logic          mod_start;
	logic [32:0]   mod_div;
	logic          mod_done;
	logic [MW-1:0] mod_rem;
	logic          hit;
	logic          allhit_n;
	logic [32:0]   xsum;
	logic [MW+1:0] tsum;
	logic [31:0]   hf;
	logic          res_take;

	bfm_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_div),
		.modulus  (modulus),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign pop       = (state_q == S_IDLE) && !fifo_empty;
	assign mod_start = (state_q == S_MST);
	assign kr_addr   = {job_q.bank, widx_q[KIW-1:0]};
	assign br_addr   = AW'(r_q >> 5);
	assign hit       = br_data[r_q[4:0]];
	assign allhit_n  = allhit_q && hit;
	assign xsum      = {1'b0, x_q} + {1'b0, b_q};
	assign tsum      = {2'b00, r_q} + {2'b00, bm_q} - (xsum[32] ? {2'b00, c_q} : '0);
	assign hf        = h_q ^ (h_q >> 15);
	assign res_take  = (state_q == S_RES) && (!oval_q || resp.ready);

	always_comb begin
		case (msel_q)
			2'd0:    mod_div = {1'b0, a_q};
			2'd1:    mod_div = {1'b0, b_q};
			default: mod_div = bfm_pkg::TWO_POW_32;
		endcase
	end

	always_comb begin
		bw_en   = 1'b0;
		bw_addr = br_addr;
		bw_data = br_data | (32'd1 << r_q[4:0]);
		if (state_q == S_CLR) begin
			bw_en   = 1'b1;
			bw_addr = clr_q;
			bw_data = '0;
		end else if (state_q == S_PCHK && !hit && job_q.op == bfm_pkg::OP_ADD) begin
			bw_en = 1'b1;
		end
	end

	assign status.key_done  = res_take;
	assign status.init_busy = init_q;

	assign resp.valid   = oval_q;
	assign resp.present = opres_q;
	assign resp.status  = ostat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			init_q  <= 1'b1;
			clr_q   <= '0;
			oval_q  <= 1'b0;
		end else begin
			if (res_take) begin
				oval_q <= 1'b1;
			end else if (resp.ready) begin
				oval_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(ROWS - 1)) begin
						clr_q   <= '0;
						init_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (!fifo_empty) begin
						if (head.op == bfm_pkg::OP_CLEAR) begin
							state_q <= S_CLR;
						end else if (head.ovf) begin
							state_q <= S_RES;
						end else begin
							state_q <= S_WRD;
						end
					end
				end
				S_WRD:   state_q <= (widx_q < job_q.len[LW-1:2]) ? S_K1 : S_TAIL;
				S_K1:    state_q <= S_K2;
				S_K2:    state_q <= S_KX;
				S_KX:    state_q <= S_WRD;
				S_TAIL:  state_q <= S_FIN1;
				S_FIN1:  state_q <= S_FIN2;
				S_FIN2:  state_q <= pass_q ? S_MST : S_WRD;
				S_MST:   state_q <= S_MWT;
				S_MWT: begin
					if (mod_done) begin
						state_q <= (msel_q == 2'd2) ? S_PINIT : S_MST;
					end
				end
				S_PINIT: state_q <= (hashes == '0) ? S_RES : S_PRD;
				S_PRD:   state_q <= S_PCHK;
				S_PCHK: begin
					if ((!hit && job_q.op == bfm_pkg::OP_CHECK) ||
						(i_q + 1'b1 == hashes)) begin
						state_q <= S_RES;
					end else begin
						state_q <= S_PFIX;
					end
				end
				S_PFIX:  state_q <= S_PRD;
				S_RES: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			opres_q <= res_present_q;
			ostat_q <= res_status_q;
		end
		case (state_q)
			S_IDLE: begin
				job_q         <= head;
				h_q           <= bfm_pkg::SEED_FIRST ^ 32'(head.len);
				pass_q        <= 1'b0;
				widx_q        <= '0;
				res_present_q <= 1'b0;
				res_status_q  <= head.ovf;
			end
			S_K1: begin
				k_q  <= bfm_pkg::mul_mix(kr_data);
				hm_q <= bfm_pkg::mul_mix(h_q);
			end
			S_K2: k_q <= bfm_pkg::mul_mix(k_q ^ (k_q >> 24));
			S_KX: begin
				h_q    <= hm_q ^ k_q;
				widx_q <= widx_q + 1'b1;
			end
			S_TAIL: begin
				if (job_q.len[1:0] != 2'd0) begin
					h_q <= bfm_pkg::mul_mix(h_q ^ job_q.tail);
				end
			end
			S_FIN1: h_q <= bfm_pkg::mul_mix(h_q ^ (h_q >> 13));
			S_FIN2: begin
				if (!pass_q) begin
					a_q    <= hf;
					h_q    <= hf ^ 32'(job_q.len);
					pass_q <= 1'b1;
					widx_q <= '0;
				end else begin
					b_q    <= hf;
					msel_q <= 2'd0;
				end
			end
			S_MWT: begin
				if (mod_done) begin
					msel_q <= msel_q + 2'd1;
					case (msel_q)
						2'd0:    r_q  <= mod_rem;
						2'd1:    bm_q <= mod_rem;
						default: c_q  <= mod_rem;
					endcase
				end
			end
			S_PINIT: begin
				x_q           <= a_q;
				i_q           <= '0;
				allhit_q      <= 1'b1;
				res_present_q <= 1'b1;
			end
			S_PCHK: begin
				allhit_q      <= allhit_n;
				res_present_q <= allhit_n;
				i_q           <= i_q + 1'b1;
				x_q           <= xsum[31:0];
				t_q           <= tsum;
			end
			S_PFIX: begin
				if (t_q[MW+1]) begin
					r_q <= MW'(t_q + {2'b00, modulus});
				end else if (t_q >= {2'b00, modulus}) begin
					r_q <= MW'(t_q - {2'b00, modulus});
				end else begin
					r_q <= t_q[MW-1:0];
				end
			end
			default: h_q <= h_q;
		endcase
	end

endmodule
